[hdl/lrupr_pkg.sv]
// ----------------------------------------------------------------------------
// LRU page replacement - shared types and constants
// Widths of the fixed ports, the time stamp and fault counter, and the
// control group that the scan engine drives into the frame table.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int STAMP_W      = 32;
    localparam int FAULT_W      = 32;
    localparam int PAGE_PORT_W  = 16;
    localparam int FRAME_PORT_W = 3;
    localparam int CFG_W        = 4;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // Access controls from the scan engine to the frame table
    typedef struct packed {
        logic rd_en;       // read one entry, data valid next cycle
        logic wr_en;       // write page and stamp of one entry
        logic set_valid;   // mark the written entry resident
        logic clear_all;   // drop every frame at end of run
    } table_ctrl_t;

endpackage

[hdl/lru_page_replacement_top.sv]
// ----------------------------------------------------------------------------
// LRU page replacement - top level
// Checks each page request against the active frames, refreshes the stamp
// on a hit, fills the first empty or oldest frame on a miss, and reports
// the outcome with a running fault count.
//
//   Channel    Handshake                     Payload
//   ---------  ----------------------------  ---------------------------------
//   request    start & !busy                 page, last_reference
//   config     cfg_valid & cfg_ready         cfg_data (frames_in_use)
//   result     result_valid (one cycle)      hit, frame, displaced_valid,
//                                            displaced_page, fault_count,
//                                            run_done
//
// Scan: the one read port of the frame memory paces a request, one entry
// per cycle, plus an update step; a new request is taken only when idle.
// The result strobe is registered in the update state and rises as the
// engine returns to idle.
// Reset: all frames empty, time and fault count zero, frames_in_use = 8; no
// clearing pass, resident marks clear at once.
// Stalls: the receiver cannot stall; busy holds off requests during a scan.
// ----------------------------------------------------------------------------
module lru_page_replacement_top #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request channel
    input  logic                                start,
    output logic                                busy,
    input  logic [lrupr_pkg::PAGE_PORT_W-1:0]   page,
    input  logic                                last_reference,
    // Configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]         cfg_data,
    // Result channel
    output logic                                result_valid,
    output logic                                hit,
    output logic [lrupr_pkg::FRAME_PORT_W-1:0]  frame,
    output logic                                displaced_valid,
    output logic [lrupr_pkg::PAGE_PORT_W-1:0]   displaced_page,
    output logic [lrupr_pkg::FAULT_W-1:0]       fault_count,
    output logic                                run_done
);

    // Stored page width: the port carries at most PAGE_PORT_W bits
    localparam int PW    = (PAGE_BITS < lrupr_pkg::PAGE_PORT_W) ?
                           PAGE_BITS : lrupr_pkg::PAGE_PORT_W;
    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    logic [lrupr_pkg::CFG_W-1:0]    frames_in_use_reg;
    logic [7:0]                     cfg_ext;
    logic [CNT_W-1:0]               n_active;

    lrupr_pkg::table_ctrl_t         tbl;
    logic [IDX_W-1:0]               rd_addr;
    logic [IDX_W-1:0]               wr_addr;
    logic [PW-1:0]                  wr_page;
    logic [lrupr_pkg::STAMP_W-1:0]  wr_stamp;
    logic                           rd_valid;
    logic [PW-1:0]                  rd_page;
    logic [lrupr_pkg::STAMP_W-1:0]  rd_stamp;

    logic [IDX_W-1:0]               res_frame;
    logic [PW-1:0]                  res_disp_page;
    logic [IDX_W+2:0]               frame_ext;
    logic [PW+15:0]                 disp_ext;

    // Configuration register: always ready; the user must write it only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= lrupr_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frames_in_use_reg <= cfg_data;
        end
    end

    // Clamp the frame count: zero acts as one, anything past FRAMES as FRAMES
    assign cfg_ext = {4'b0, frames_in_use_reg};

    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (int'(cfg_ext) > FRAMES)
        begin
            n_active = CNT_W'(FRAMES);
        end
        else
        begin
            n_active = cfg_ext[CNT_W-1:0];
        end
    end

    lrupr_table #(
        .FRAMES (FRAMES),
        .PW     (PW),
        .IDX_W  (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (tbl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_page  (wr_page),
        .wr_stamp (wr_stamp),
        .rd_valid (rd_valid),
        .rd_page  (rd_page),
        .rd_stamp (rd_stamp)
    );

    lrupr_scan #(
        .FRAMES (FRAMES),
        .PW     (PW),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .page_in        (page[PW-1:0]),
        .last_in        (last_reference),
        .n_active       (n_active),
        .tbl            (tbl),
        .rd_addr        (rd_addr),
        .wr_addr        (wr_addr),
        .wr_page        (wr_page),
        .wr_stamp       (wr_stamp),
        .rd_valid       (rd_valid),
        .rd_page        (rd_page),
        .rd_stamp       (rd_stamp),
        .result_valid   (result_valid),
        .res_hit        (hit),
        .res_frame      (res_frame),
        .res_disp_valid (displaced_valid),
        .res_disp_page  (res_disp_page),
        .res_faults     (fault_count),
        .res_done       (run_done)
    );

    // Fit the internal index and page widths onto the fixed result ports
    assign frame_ext      = {3'b0, res_frame};
    assign frame          = frame_ext[lrupr_pkg::FRAME_PORT_W-1:0];
    assign disp_ext       = {16'b0, res_disp_page};
    assign displaced_page = disp_ext[lrupr_pkg::PAGE_PORT_W-1:0];

endmodule

[hdl/lrupr_table.sv]
// ----------------------------------------------------------------------------
// LRU page replacement - frame table
// Synchronous memory of page number and last-use stamp per frame, one read
// and one write port, registered read data; resident marks in flip-flops.
// ----------------------------------------------------------------------------
module lrupr_table #(
    parameter int FRAMES = 8,
    parameter int PW     = 16,
    parameter int IDX_W  = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lrupr_pkg::table_ctrl_t       ctrl,
    input  logic [IDX_W-1:0]             rd_addr,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [PW-1:0]                wr_page,
    input  logic [lrupr_pkg::STAMP_W-1:0] wr_stamp,
    output logic                         rd_valid,
    output logic [PW-1:0]                rd_page,
    output logic [lrupr_pkg::STAMP_W-1:0] rd_stamp
);

    localparam int EW = PW + lrupr_pkg::STAMP_W;

    logic [EW-1:0]     frame_mem_reg [FRAMES];
    logic [EW-1:0]     rd_data_reg;
    logic              rd_valid_reg;
    logic [FRAMES-1:0] valid_reg;

    // Memory array: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            frame_mem_reg[wr_addr] <= {wr_page, wr_stamp};
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= frame_mem_reg[rd_addr];
        end
    end

    // Resident marks; end of run wins over a fill in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (ctrl.wr_en && ctrl.set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_page  = rd_data_reg[EW-1:lrupr_pkg::STAMP_W];
    assign rd_stamp = rd_data_reg[lrupr_pkg::STAMP_W-1:0];

endmodule

[hdl/lrupr_scan.sv]
// ----------------------------------------------------------------------------
// LRU page replacement - scan engine
// Walk the active frames one per cycle for a hit, the first empty frame and
// the oldest stamp, then fill the victim on a miss and emit one result.
// ----------------------------------------------------------------------------
module lrupr_scan #(
    parameter int FRAMES = 8,
    parameter int PW     = 16,
    parameter int IDX_W  = 3,
    parameter int CNT_W  = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [PW-1:0]                 page_in,
    input  logic                          last_in,
    input  logic [CNT_W-1:0]              n_active,
    output lrupr_pkg::table_ctrl_t        tbl,
    output logic [IDX_W-1:0]              rd_addr,
    output logic [IDX_W-1:0]              wr_addr,
    output logic [PW-1:0]                 wr_page,
    output logic [lrupr_pkg::STAMP_W-1:0] wr_stamp,
    input  logic                          rd_valid,
    input  logic [PW-1:0]                 rd_page,
    input  logic [lrupr_pkg::STAMP_W-1:0] rd_stamp,
    output logic                          result_valid,
    output logic                          res_hit,
    output logic [IDX_W-1:0]              res_frame,
    output logic                          res_disp_valid,
    output logic [PW-1:0]                 res_disp_page,
    output logic [lrupr_pkg::FAULT_W-1:0] res_faults,
    output logic                          res_done
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE} state_t;

    state_t                          state_reg, state_next;
    logic [PW-1:0]                   pg_reg, pg_next;
    logic                            last_reg, last_next;
    logic [CNT_W-1:0]                n_reg, n_next;
    logic [lrupr_pkg::STAMP_W-1:0]   time_reg, time_next;
    logic [lrupr_pkg::FAULT_W-1:0]   faults_reg, faults_next;
    logic [CNT_W-1:0]                issue_reg, issue_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]                cmp_cnt_reg, cmp_cnt_next;
    logic                            hit_reg, hit_next;
    logic [IDX_W-1:0]                used_reg, used_next;
    logic                            empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]                empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]                best_idx_reg, best_idx_next;
    logic [lrupr_pkg::STAMP_W-1:0]   best_stamp_reg, best_stamp_next;
    logic [PW-1:0]                   best_page_reg, best_page_next;
    logic                            rv_reg, rv_next;
    logic                            r_hit_reg, r_hit_next;
    logic [IDX_W-1:0]                r_frame_reg, r_frame_next;
    logic                            r_dv_reg, r_dv_next;
    logic [PW-1:0]                   r_dp_reg, r_dp_next;
    logic [lrupr_pkg::FAULT_W-1:0]   r_faults_reg, r_faults_next;
    logic                            r_done_reg, r_done_next;

    logic [IDX_W-1:0] cmp_idx;
    logic             cmp_last;
    logic             match;

    assign cmp_idx  = cmp_cnt_reg[IDX_W-1:0];
    assign cmp_last = (CNT_W'(cmp_cnt_reg + 1'b1) == n_reg);
    assign match    = rd_valid && (rd_page == pg_reg);

    always_comb
    begin
        state_next       = state_reg;
        pg_next          = pg_reg;
        last_next        = last_reg;
        n_next           = n_reg;
        time_next        = time_reg;
        faults_next      = faults_reg;
        issue_next       = issue_reg;
        cmp_valid_next   = 1'b0;
        cmp_cnt_next     = cmp_cnt_reg;
        hit_next         = hit_reg;
        used_next        = used_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        best_idx_next    = best_idx_reg;
        best_stamp_next  = best_stamp_reg;
        best_page_next   = best_page_reg;
        rv_next          = 1'b0;
        r_hit_next       = r_hit_reg;
        r_frame_next     = r_frame_reg;
        r_dv_next        = r_dv_reg;
        r_dp_next        = r_dp_reg;
        r_faults_next    = r_faults_reg;
        r_done_next      = r_done_reg;
        tbl              = '0;
        rd_addr          = issue_reg[IDX_W-1:0];
        wr_addr          = cmp_idx;
        wr_page          = rd_page;
        wr_stamp         = time_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pg_next          = page_in;
                    last_next        = last_in;
                    n_next           = n_active;
                    issue_next       = '0;
                    hit_next         = 1'b0;
                    empty_found_next = 1'b0;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Issue the next read while the previous entry is checked
                if (issue_reg < n_reg)
                begin
                    tbl.rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_cnt_next   = issue_reg;
                    issue_next     = CNT_W'(issue_reg + 1'b1);
                end
                if (cmp_valid_reg)
                begin
                    if (match)
                    begin
                        // Refresh every matching frame, report the first
                        tbl.wr_en = 1'b1;
                        if (!hit_reg)
                        begin
                            used_next = cmp_idx;
                        end
                        hit_next = 1'b1;
                    end
                    if (!rd_valid && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = cmp_idx;
                    end
                    if (cmp_cnt_reg == '0 || rd_stamp < best_stamp_reg)
                    begin
                        best_idx_next   = cmp_idx;
                        best_stamp_next = rd_stamp;
                        best_page_next  = rd_page;
                    end
                    if (cmp_last)
                    begin
                        state_next = S_UPDATE;
                    end
                end
            end
            S_UPDATE:
            begin
                r_hit_next   = hit_reg;
                r_dv_next    = 1'b0;
                r_dp_next    = '0;
                r_frame_next = used_reg;
                faults_next  = faults_reg;
                if (!hit_reg)
                begin
                    wr_addr       = empty_found_reg ? empty_idx_reg : best_idx_reg;
                    wr_page       = pg_reg;
                    tbl.wr_en     = 1'b1;
                    tbl.set_valid = 1'b1;
                    r_frame_next  = wr_addr;
                    if (!empty_found_reg)
                    begin
                        r_dv_next = 1'b1;
                        r_dp_next = best_page_reg;
                    end
                    if (faults_reg != lrupr_pkg::FAULT_MAX)
                    begin
                        faults_next = faults_reg + 1'b1;
                    end
                end
                r_faults_next = faults_next;
                r_done_next   = last_reg;
                rv_next       = 1'b1;
                if (time_reg != lrupr_pkg::STAMP_MAX)
                begin
                    time_next = time_reg + 1'b1;
                end
                if (last_reg)
                begin
                    tbl.clear_all = 1'b1;
                    time_next     = '0;
                    faults_next   = '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pg_reg          <= '0;
            last_reg        <= 1'b0;
            n_reg           <= '0;
            time_reg        <= '0;
            faults_reg      <= '0;
            issue_reg       <= '0;
            cmp_valid_reg   <= 1'b0;
            cmp_cnt_reg     <= '0;
            hit_reg         <= 1'b0;
            used_reg        <= '0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            best_idx_reg    <= '0;
            best_stamp_reg  <= '0;
            best_page_reg   <= '0;
            rv_reg          <= 1'b0;
            r_hit_reg       <= 1'b0;
            r_frame_reg     <= '0;
            r_dv_reg        <= 1'b0;
            r_dp_reg        <= '0;
            r_faults_reg    <= '0;
            r_done_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pg_reg          <= pg_next;
            last_reg        <= last_next;
            n_reg           <= n_next;
            time_reg        <= time_next;
            faults_reg      <= faults_next;
            issue_reg       <= issue_next;
            cmp_valid_reg   <= cmp_valid_next;
            cmp_cnt_reg     <= cmp_cnt_next;
            hit_reg         <= hit_next;
            used_reg        <= used_next;
            empty_found_reg <= empty_found_next;
            empty_idx_reg   <= empty_idx_next;
            best_idx_reg    <= best_idx_next;
            best_stamp_reg  <= best_stamp_next;
            best_page_reg   <= best_page_next;
            rv_reg          <= rv_next;
            r_hit_reg       <= r_hit_next;
            r_frame_reg     <= r_frame_next;
            r_dv_reg        <= r_dv_next;
            r_dp_reg        <= r_dp_next;
            r_faults_reg    <= r_faults_next;
            r_done_reg      <= r_done_next;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign result_valid   = rv_reg;
    assign res_hit        = r_hit_reg;
    assign res_frame      = r_frame_reg;
    assign res_disp_valid = r_dv_reg;
    assign res_disp_page  = r_dp_reg;
    assign res_faults     = r_faults_reg;
    assign res_done       = r_done_reg;

    // A result only appears once the engine is back in idle
    a_result_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    // Eviction only ever happens on a miss
    a_disp_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && r_dv_reg) |-> !r_hit_reg)
        else $error("displaced page reported on a hit");

    // A miss has counted at least one fault
    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && !r_hit_reg) |-> (r_faults_reg != '0))
        else $error("miss reported with zero fault count");

    // Stamp write-back never collides with the read issued beside it
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (tbl.rd_en && tbl.wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write to the same frame in one cycle");

    // A started scan always begins with no compare pending from an earlier one
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_SCAN && !cmp_valid_reg))
        else $error("scan entered with a stale compare");

endmodule
